// File: rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// shared types and constants of the minimum coin change block
// ----------------------------------------------------------------------------
`default_nettype none
package mcc_pkg;
  localparam int unsigned AmountW    = 10;
  localparam int unsigned CoinW      = 10;
  localparam int unsigned NumCoinsW  = 3;
  localparam int unsigned SlotRegs   = 6;
  localparam int unsigned MaxAmount  = 1023;
  localparam int unsigned MaxCoins   = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 10;

  localparam logic [CfgIdxW-1:0] REG_NUM_COINS = 3'd0;
endpackage
`default_nettype wire

// File: rtl/mcc_ram.sv
// ----------------------------------------------------------------------------
// mcc_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module mcc_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/min_coin_change.sv
// ----------------------------------------------------------------------------
// min_coin_change
// fewest coins for a target amount by table fill and traceback
// ----------------------------------------------------------------------------
//  channel | signals                           | dir
//  in      | in_valid in_stall amount          | in
//  out     | out_valid out_stall reachable ... | out
//  cfg     | cfg_valid cfg_ready cfg_index ... | in
//
//  fill: per amount i, one write state, then per usable slot a check and a
//  read state, per other slot a check only, and a final check; traceback
//  steps down through the slots with a read each, per coin taken.
//  the single ram port sets the rate; one item in flight at a time.
//  rst is synchronous; the table needs no clearing as entries are written
//  before read. a stalled result holds while the next item runs.
// ----------------------------------------------------------------------------
`default_nettype none
module min_coin_change #(
  parameter int unsigned MAX_AMOUNT = mcc_pkg::MaxAmount,
  parameter int unsigned MAX_COINS  = mcc_pkg::MaxCoins
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mcc_pkg::AmountW-1:0]   amount,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               reachable,
  output logic [9:0]                         total_coins,
  output logic [9:0]                         count_slot_0,
  output logic [9:0]                         count_slot_1,
  output logic [9:0]                         count_slot_2,
  output logic [9:0]                         count_slot_3,
  output logic [9:0]                         count_slot_4,
  output logic [9:0]                         count_slot_5,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [mcc_pkg::CfgDataW-1:0]  cfg_data
);
  import mcc_pkg::*;

  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = $clog2(MAX_AMOUNT + 2);
  localparam logic [VW-1:0] NO_WAY = VW'(MAX_AMOUNT + 1);
  localparam int unsigned SW    = 3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_FRD   = 7'b0000100,
    S_FWR   = 7'b0001000,
    S_TOT   = 7'b0010000,
    S_TRD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t              state;
  logic [NumCoinsW-1:0] num_coins;
  logic [CoinW-1:0]    coin [SlotRegs];
  logic [SW-1:0]       slots;
  logic [AmountW:0]    amt;
  logic [AmountW:0]    idx;
  logic [SW-1:0]       slot;
  logic [VW-1:0]       best;
  logic [VW-1:0]       cur;
  logic [9:0]          total;
  logic [9:0]          cnt [SlotRegs];
  logic                reach;
  logic                pend;

  logic                we;
  logic [AW-1:0]       addr;
  logic [VW-1:0]       wdata;
  logic [VW-1:0]       rdata;

  mcc_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_table (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign slots = (num_coins > SW'(MAX_COINS)) ? SW'(MAX_COINS) : num_coins;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  logic [CoinW-1:0] cv;
  logic             cok;
  assign cv  = (slot < SW'(SlotRegs)) ? coin[slot] : '0;
  assign cok = (slot < slots) && (cv != '0) && ({1'b0, cv} <= idx);

  logic [VW-1:0] fbest;
  assign fbest = (best >= NO_WAY) ? NO_WAY : best + VW'(1);

  always_comb begin
    we    = 1'b0;
    addr  = idx[AW-1:0] - AW'(cv);
    wdata = (idx == '0) ? '0 : fbest;
    unique case (state)
      S_FWR: begin
        we   = 1'b1;
        addr = idx[AW-1:0];
      end
      S_TOT: addr = idx[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      num_coins <= '0;
      for (int k = 0; k < SlotRegs; k++) coin[k] <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_NUM_COINS) begin
          num_coins <= cfg_data[NumCoinsW-1:0];
        end else if (cfg_index <= CfgIdxW'(SlotRegs)) begin
          coin[cfg_index - CfgIdxW'(1)] <= cfg_data[CoinW-1:0];
        end
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            amt   <= {1'b0, amount};
            reach <= 1'b0;
            total <= '0;
            for (int k = 0; k < SlotRegs; k++) cnt[k] <= '0;
            if ({1'b0, amount} > (AmountW+1)'(MAX_AMOUNT)) begin
              state <= S_OUT;
            end else begin
              idx   <= '0;
              best  <= NO_WAY;
              slot  <= '0;
              state <= S_FWR;
            end
          end
        end
        S_FILL: begin
          if (slot >= slots) begin
            state <= S_FWR;
          end else if (cok) begin
            state <= S_FRD;
          end else begin
            slot <= slot + SW'(1);
          end
        end
        S_FRD: begin
          if (rdata < best) best <= rdata;
          slot  <= slot + SW'(1);
          state <= S_FILL;
        end
        S_FWR: begin
          if (idx == amt) begin
            state <= S_TOT;
            pend  <= 1'b1;
          end else begin
            idx   <= idx + 1'b1;
            best  <= NO_WAY;
            slot  <= '0;
            state <= S_FILL;
          end
        end
        S_TOT: begin
          if (pend) begin
            state <= S_TOT;
          end else if (idx == amt && rdata >= NO_WAY) begin
            state <= S_OUT;
          end else begin
            if (idx == amt) begin
              reach <= 1'b1;
              total <= rdata[9:0];
            end
            cur <= rdata;
            if (idx == '0) begin
              reach <= 1'b1;
              state <= S_OUT;
            end else begin
              slot  <= slots - SW'(1);
              state <= S_TRD;
              pend  <= 1'b1;
            end
          end
        end
        S_TRD: begin
          if (pend) begin
            state <= S_TRD;
          end else if (cok && (rdata + VW'(1) == cur)) begin
            idx   <= idx - (AmountW+1)'(cv);
            cnt[slot] <= cnt[slot] + 10'd1;
            state <= S_TOT;
            pend  <= 1'b1;
          end else if (slot == '0) begin
            state <= S_OUT;
          end else begin
            slot <= slot - SW'(1);
            pend <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid    <= 1'b1;
            reachable    <= reach;
            total_coins  <= total;
            count_slot_0 <= cnt[0];
            count_slot_1 <= cnt[1];
            count_slot_2 <= cnt[2];
            count_slot_3 <= cnt[3];
            count_slot_4 <= cnt[4];
            count_slot_5 <= cnt[5];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
